// ----- sv/html_entity_decoder_top_defines.svh -----
// Assertion macros shared by the decoder's checking code.
`ifndef HTML_ENTITY_DECODER_TOP_DEFINES_SVH
`define HTML_ENTITY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HED_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hed_pkg.sv -----
package hed_pkg;

    // Entity body buffer geometry (circular addressing needs a power of two)
    localparam int MaxBody    = 32;
    localparam int AdrW       = $clog2(MaxBody);
    localparam int CntW       = $clog2(MaxBody + 1);
    localparam int PtrW       = $clog2(MaxBody + 2);
    localparam int NamedCount = 32;
    localparam int QDepth     = 2;
    localparam int QAdrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);
    localparam int CpW        = 21;

    // Characters with a role in the syntax
    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChSemi = 8'h3B;
    localparam logic [7:0] ChHash = 8'h23;
    localparam logic [7:0] ChXLo  = 8'h78;
    localparam logic [7:0] ChXUp  = 8'h58;

    localparam logic [CpW-1:0] CpMax   = 21'h10FFFF;
    localparam logic [CpW-1:0] CpClamp = 21'h110000;
    localparam logic [CpW-1:0] SurLo   = 21'h00D800;
    localparam logic [CpW-1:0] SurHi   = 21'h00DFFF;

    // One queued request
    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        logic       amp;
        logic       semi;
    } t_qitem;

    // Back end status
    typedef struct packed {
        logic            idle;
        logic            pend_v;
        logic [CntW-1:0] count;
    } t_bstat;

    // Named entity: name and UTF-8 text, both right-aligned
    typedef struct packed {
        logic [47:0] name;
        logic [2:0]  nlen;
        logic [23:0] utf;
        logic [1:0]  ulen;
    } t_named;

    // Encoded result bytes, right-aligned, first byte most significant
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } t_res;

    function automatic t_named named_ref(input int unsigned idx);
        t_named r;
        case (idx)
            0:  r = '{48'("amp"),    3'd3, 24'h000026, 2'd1};
            1:  r = '{48'("lt"),     3'd2, 24'h00003C, 2'd1};
            2:  r = '{48'("gt"),     3'd2, 24'h00003E, 2'd1};
            3:  r = '{48'("quot"),   3'd4, 24'h000022, 2'd1};
            4:  r = '{48'("apos"),   3'd4, 24'h000027, 2'd1};
            5:  r = '{48'("nbsp"),   3'd4, 24'h00C2A0, 2'd2};
            6:  r = '{48'("middot"), 3'd6, 24'h00C2B7, 2'd2};
            7:  r = '{48'("sect"),   3'd4, 24'h00C2A7, 2'd2};
            8:  r = '{48'("para"),   3'd4, 24'h00C2B6, 2'd2};
            9:  r = '{48'("laquo"),  3'd5, 24'h00C2AB, 2'd2};
            10: r = '{48'("raquo"),  3'd5, 24'h00C2BB, 2'd2};
            11: r = '{48'("copy"),   3'd4, 24'h00C2A9, 2'd2};
            12: r = '{48'("reg"),    3'd3, 24'h00C2AE, 2'd2};
            13: r = '{48'("deg"),    3'd3, 24'h00C2B0, 2'd2};
            14: r = '{48'("plusmn"), 3'd6, 24'h00C2B1, 2'd2};
            15: r = '{48'("times"),  3'd5, 24'h00C397, 2'd2};
            16: r = '{48'("divide"), 3'd6, 24'h00C3B7, 2'd2};
            17: r = '{48'("ndash"),  3'd5, 24'hE28093, 2'd3};
            18: r = '{48'("mdash"),  3'd5, 24'hE28094, 2'd3};
            19: r = '{48'("lsquo"),  3'd5, 24'hE28098, 2'd3};
            20: r = '{48'("rsquo"),  3'd5, 24'hE28099, 2'd3};
            21: r = '{48'("ldquo"),  3'd5, 24'hE2809C, 2'd3};
            22: r = '{48'("rdquo"),  3'd5, 24'hE2809D, 2'd3};
            23: r = '{48'("bull"),   3'd4, 24'hE280A2, 2'd3};
            24: r = '{48'("hellip"), 3'd6, 24'hE280A6, 2'd3};
            25: r = '{48'("euro"),   3'd4, 24'hE282AC, 2'd3};
            26: r = '{48'("trade"),  3'd5, 24'hE284A2, 2'd3};
            27: r = '{48'("larr"),   3'd4, 24'hE28690, 2'd3};
            28: r = '{48'("uarr"),   3'd4, 24'hE28691, 2'd3};
            29: r = '{48'("rarr"),   3'd4, 24'hE28692, 2'd3};
            30: r = '{48'("darr"),   3'd4, 24'hE28693, 2'd3};
            31: r = '{48'("harr"),   3'd4, 24'hE28694, 2'd3};
            default: r = '{48'h0, 3'd0, 24'h0, 2'd0};
        endcase
        return r;
    endfunction

    // {valid, value} of a decimal or hex digit
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return {1'b0, t[3:0]};
    endfunction

    // Code point to UTF-8; invalid values give U+FFFD
    function automatic t_res utf8_enc(input logic [CpW-1:0] cp);
        t_res r;
        if (cp == '0 || cp > CpMax || (cp >= SurLo && cp <= SurHi)) begin
            r = '{32'h00EFBFBD, 3'd3};
        end else if (cp < 21'h80) begin
            r = '{{24'h0, cp[7:0]}, 3'd1};
        end else if (cp < 21'h800) begin
            r = '{{16'h0, 3'b110, cp[10:6], 2'b10, cp[5:0]}, 3'd2};
        end else if (cp < 21'h10000) begin
            r = '{{8'h0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]}, 3'd3};
        end else begin
            r = '{{5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                   2'b10, cp[5:0]}, 3'd4};
        end
        return r;
    endfunction

endpackage

// ----- sv/hed_front.sv -----
module hed_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_text,
    output hed_pkg::t_qitem   o_q,
    output logic              o_q_valid,
    input  logic              i_pop
);

    hed_pkg::t_qitem                r_q [hed_pkg::QDepth];
    logic [hed_pkg::QAdrW-1:0]      r_wp, r_rp;
    logic [hed_pkg::QCntW-1:0]      r_cnt;
    logic                           push;
    logic                           pop;
    hed_pkg::t_qitem                item;

    // Classify the incoming byte
    always_comb begin
        item.b    = i_text_byte;
        item.eot  = i_end_of_text;
        item.amp  = (i_text_byte == hed_pkg::ChAmp);
        item.semi = (i_text_byte == hed_pkg::ChSemi);
    end

    assign o_stall   = (r_cnt == hed_pkg::QCntW'(hed_pkg::QDepth));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_pop && o_q_valid;
    assign o_q       = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- sv/hed_back.sv -----
module hed_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hed_pkg::t_qitem   i_q,
    input  logic              i_q_valid,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run,
    output logic              o_text_done,
    output hed_pkg::t_bstat   o_stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_RES    = 3'd4;
    localparam logic [2:0] ST_LIT    = 3'd5;
    localparam logic [2:0] ST_OVF    = 3'd6;
    localparam logic [2:0] ST_EOT    = 3'd7;

    localparam int CntW = hed_pkg::CntW;
    localparam int PtrW = hed_pkg::PtrW;
    localparam int AdrW = hed_pkg::AdrW;
    localparam int CpW  = hed_pkg::CpW;

    logic [7:0]                 r_store [hed_pkg::MaxBody];
    logic [2:0]                 r_state, n_state;
    logic                       r_in_ent, n_in_ent;
    logic [CntW-1:0]            r_count, n_count;
    logic [AdrW-1:0]            r_head, n_head;
    logic [PtrW-1:0]            r_ptr, n_ptr;
    hed_pkg::t_qitem            r_item, n_item;
    logic [hed_pkg::NamedCount-1:0] r_cand, n_cand;
    logic                       r_nok, n_nok;
    logic                       r_hex, n_hex;
    logic                       r_hd, n_hd;
    logic [CpW-1:0]             r_cp, n_cp;
    logic [31:0]                r_res, n_res;
    logic [2:0]                 r_rlen, n_rlen;
    logic                       r_pend_v, n_pend_v;
    logic [7:0]                 r_pend_b, n_pend_b;
    logic                       r_out_v, n_out_v;
    logic [7:0]                 r_out_b, n_out_b;
    logic                       r_out_last, n_out_last;
    logic                       r_out_done, n_out_done;

    logic [7:0]                 rd;
    logic                       slot_free;
    logic                       can_emit;
    logic                       emit;
    logic [7:0]                 ebyte;
    logic                       fin;
    logic                       we;
    logic [AdrW-1:0]            waddr;
    logic [7:0]                 wdata;
    logic [4:0]                 dg;
    logic [CpW+3:0]             acc;
    logic                       hit;
    hed_pkg::t_named            nr;
    hed_pkg::t_named            hres;
    hed_pkg::t_res              enc;
    logic [47:0]                nsh;
    logic [31:0]                rsh;
    logic [7:0]                 ob;

    // Single read port of the body buffer, relative to the head
    assign rd        = r_store[r_head + r_ptr[AdrW-1:0]];
    assign slot_free = !r_out_v || !i_stall;
    assign can_emit  = !r_pend_v || slot_free;

    // Digit decode and accumulate; the clamp is applied in the sequencer
    always_comb begin
        dg = hed_pkg::digit_of(rd, r_hex);
        if (r_hex) begin
            acc = {r_cp, 4'b0000} + {(CpW)'(0), dg[3:0]};
        end else begin
            acc = {1'b0, r_cp, 3'b000} + {3'b000, r_cp, 1'b0} + {(CpW)'(0), dg[3:0]};
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_in_ent = r_in_ent;
        n_count  = r_count;
        n_head   = r_head;
        n_ptr    = r_ptr;
        n_item   = r_item;
        n_cand   = r_cand;
        n_nok    = r_nok;
        n_hex    = r_hex;
        n_hd     = r_hd;
        n_cp     = r_cp;
        n_res    = r_res;
        n_rlen   = r_rlen;
        emit     = 1'b0;
        ebyte    = 8'h00;
        fin      = 1'b0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = 8'h00;
        o_pop    = 1'b0;
        hit      = 1'b0;
        nr       = '0;
        hres     = '0;
        nsh      = '0;
        rsh      = '0;
        ob       = 8'h00;
        enc      = hed_pkg::utf8_enc(r_cp);

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_q;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (!r_in_ent) begin
                    if (r_item.amp) begin
                        n_in_ent = 1'b1;
                        n_count  = '0;
                        n_state  = ST_EOT;
                    end else if (can_emit) begin
                        emit    = 1'b1;
                        ebyte   = r_item.b;
                        n_state = ST_EOT;
                    end
                end else if (r_item.semi) begin
                    n_ptr   = '0;
                    n_cand  = '1;
                    n_nok   = 1'b0;
                    n_hex   = 1'b0;
                    n_hd    = 1'b0;
                    n_cp    = '0;
                    n_state = ST_SCAN;
                end else if (r_count < CntW'(hed_pkg::MaxBody)) begin
                    we      = 1'b1;
                    waddr   = r_head + r_count[AdrW-1:0];
                    wdata   = r_item.b;
                    n_count = r_count + 1'b1;
                    n_state = ST_EOT;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    ebyte   = hed_pkg::ChAmp;
                    n_ptr   = '0;
                    n_state = ST_OVF;
                end
            end
            ST_SCAN: begin
                // one body byte per cycle: name candidates and numeric parse
                if (r_ptr < PtrW'(r_count)) begin
                    for (int j = 0; j < hed_pkg::NamedCount; j++) begin
                        nr = hed_pkg::named_ref(j);
                        if (r_ptr >= PtrW'(nr.nlen)) begin
                            n_cand[j] = 1'b0;
                        end else begin
                            nsh = nr.name >> (8 * (int'(nr.nlen) - 1 - int'(r_ptr)));
                            if (nsh[7:0] != rd) begin
                                n_cand[j] = 1'b0;
                            end
                        end
                    end
                    if (r_ptr == '0) begin
                        n_nok = (rd == hed_pkg::ChHash);
                    end else if (r_ptr == PtrW'(1) &&
                                 (rd == hed_pkg::ChXLo || rd == hed_pkg::ChXUp)) begin
                        n_hex = 1'b1;
                    end else if (dg[4]) begin
                        n_hd = 1'b1;
                        n_cp = (acc > (CpW+4)'(hed_pkg::CpMax)) ? hed_pkg::CpClamp
                                                                : acc[CpW-1:0];
                    end else begin
                        n_nok = 1'b0;
                    end
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                for (int j = 0; j < hed_pkg::NamedCount; j++) begin
                    nr = hed_pkg::named_ref(j);
                    if (!hit && r_cand[j] && CntW'(nr.nlen) == r_count) begin
                        hit  = 1'b1;
                        hres = nr;
                    end
                end
                if (hit) begin
                    n_res   = {8'h00, hres.utf};
                    n_rlen  = {1'b0, hres.ulen};
                    n_ptr   = '0;
                    n_state = ST_RES;
                end else if (r_nok && r_hd) begin
                    n_res   = enc.bytes;
                    n_rlen  = enc.len;
                    n_ptr   = '0;
                    n_state = ST_RES;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    ebyte   = hed_pkg::ChAmp;
                    n_ptr   = '0;
                    n_state = ST_LIT;
                end
            end
            ST_RES: begin
                if (r_ptr < PtrW'(r_rlen)) begin
                    if (can_emit) begin
                        rsh   = r_res >> (8 * (int'(r_rlen) - 1 - int'(r_ptr)));
                        emit  = 1'b1;
                        ebyte = rsh[7:0];
                        n_ptr = r_ptr + 1'b1;
                    end
                end else begin
                    n_in_ent = 1'b0;
                    n_count  = '0;
                    n_state  = ST_EOT;
                end
            end
            ST_LIT: begin
                // literal echo of the body, closed by ';' for a bad reference, unclosed on an end-of-text flush
                if (r_ptr < PtrW'(r_count)) begin
                    if (can_emit) begin
                        emit  = 1'b1;
                        ebyte = rd;
                        n_ptr = r_ptr + 1'b1;
                    end
                end else if (r_item.semi) begin
                    if (can_emit) begin
                        emit     = 1'b1;
                        ebyte    = hed_pkg::ChSemi;
                        n_in_ent = 1'b0;
                        n_count  = '0;
                        n_state  = ST_EOT;
                    end
                end else begin
                    n_in_ent = 1'b0;
                    n_count  = '0;
                    n_state  = ST_EOT;
                end
            end
            ST_OVF: begin
                // held bytes plus new byte, up to the first '&'
                ob = (r_ptr == PtrW'(hed_pkg::MaxBody)) ? r_item.b : rd;
                if (ob == hed_pkg::ChAmp) begin
                    n_in_ent = 1'b1;
                    if (r_ptr < PtrW'(hed_pkg::MaxBody)) begin
                        we      = 1'b1;
                        waddr   = r_head;
                        wdata   = r_item.b;
                        n_head  = r_head + r_ptr[AdrW-1:0] + 1'b1;
                        n_count = CntW'(hed_pkg::MaxBody) - CntW'(r_ptr);
                    end else begin
                        n_count = '0;
                    end
                    n_state = ST_EOT;
                end else if (can_emit) begin
                    emit  = 1'b1;
                    ebyte = ob;
                    if (r_ptr == PtrW'(hed_pkg::MaxBody)) begin
                        n_in_ent = 1'b0;
                        n_count  = '0;
                        n_state  = ST_EOT;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            ST_EOT: begin
                if (r_item.eot && r_in_ent) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        ebyte   = hed_pkg::ChAmp;
                        n_ptr   = '0;
                        n_state = ST_LIT;
                    end
                end else begin
                    if (r_item.eot) begin
                        n_in_ent = 1'b0;
                        n_count  = '0;
                    end
                    if (can_emit) begin
                        fin     = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Pending byte and output register: last flag known once the next byte exists
    always_comb begin
        n_pend_v   = r_pend_v;
        n_pend_b   = r_pend_b;
        n_out_v    = r_out_v && i_stall;
        n_out_b    = r_out_b;
        n_out_last = r_out_last;
        n_out_done = r_out_done;
        if (emit) begin
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_b    = r_pend_b;
                n_out_last = 1'b0;
                n_out_done = 1'b0;
            end
            n_pend_v = 1'b1;
            n_pend_b = ebyte;
        end else if (fin) begin
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out_b    = r_pend_b;
                n_out_last = 1'b1;
                n_out_done = r_item.eot;
            end
            n_pend_v = 1'b0;
        end
    end

    // Body buffer
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_item     <= n_item;
        r_cand     <= n_cand;
        r_nok      <= n_nok;
        r_hex      <= n_hex;
        r_hd       <= n_hd;
        r_cp       <= n_cp;
        r_res      <= n_res;
        r_rlen     <= n_rlen;
        r_pend_b   <= n_pend_b;
        r_out_b    <= n_out_b;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_in_ent <= 1'b0;
            r_count  <= '0;
            r_head   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_ent <= n_in_ent;
            r_count  <= n_count;
            r_head   <= n_head;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    assign o_valid       = r_out_v;
    assign o_out_byte    = r_out_b;
    assign o_last_of_run = r_out_last;
    assign o_text_done   = r_out_done;
    assign o_stat.idle   = (r_state == ST_IDLE);
    assign o_stat.pend_v = r_pend_v;
    assign o_stat.count  = r_count;

endmodule

// ----- sv/html_entity_decoder_top.sv -----
// HTML character reference decoder with UTF-8 output.
// Input channel: i_valid / o_stall carries one text byte plus an end-of-text
// flag; a request is taken on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carries one output byte with last-of-run
// (final byte caused by one input) and text-done (final byte of the text).
// A two-entry queue sits in front of the decode sequencer, and a registered
// output stage after it, so the input side keeps accepting while a result
// waits on i_stall, until the queue fills. Output holds steady while i_stall
// is high.
// A plain byte passes through the IDLE, START and EOT states. A ';' runs the
// name/number scan over the buffered body bytes, then a decide step, then
// emits the result bytes. Overflow and end-of-text flushes emit one byte per
// cycle while the output is not stalled. A plain byte passes from the queue
// through the sequencer, the pending byte register and the output register.
// Reset (synchronous, active low) empties the queue, drops any open entity
// and the pending output byte. The body buffer has no reset and no clearing
// pass; it is read only at entries written for the current entity.
module html_entity_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_text_done
);

`include "html_entity_decoder_top_defines.svh"

    hed_pkg::t_qitem w_q;
    logic            w_q_valid;
    logic            w_pop;
    hed_pkg::t_bstat w_stat;

    hed_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .i_end_of_text(i_end_of_text),
        .o_q          (w_q),
        .o_q_valid    (w_q_valid),
        .i_pop        (w_pop)
    );

    hed_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (w_q),
        .i_q_valid    (w_q_valid),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run),
        .o_text_done  (o_text_done),
        .o_stat       (w_stat)
    );

    // Checks
    `HED_ASSERT_IMP(a_done_is_last, o_valid && o_text_done, o_last_of_run, "done without last")
    `HED_ASSERT_IMP(a_idle_no_pend, w_stat.idle, !w_stat.pend_v, "pending byte left when idle")
    `HED_ASSERT_IMP(a_count_max, 1'b1, w_stat.count <= hed_pkg::CntW'(hed_pkg::MaxBody), "body count overrun")
    `HED_ASSERT_NEXT(a_pop_busy, w_pop, !w_stat.idle, "pop without starting work")

endmodule

// ----- test/html_entity_decoder_checker.sv -----
module html_entity_decoder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall_in,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_last_of_run,
    input  logic       i_text_done,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       done;
    } t_decoded;

    // Decoder state mirror
    logic       open_ent;
    logic [7:0] body_q[$];
    logic [7:0] run_q[$];
    t_decoded   decoded_q[$];

    function automatic string body_str();
        string s;
        s = "";
        foreach (body_q[k]) s = {s, string'(body_q[k])};
        return s;
    endfunction

    function automatic void put_cp(input int unsigned cp);
        if (cp == 0 || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
            run_q = {run_q, 8'hEF, 8'hBF, 8'hBD};
        end else if (cp < 32'h80) begin
            run_q = {run_q, cp[7:0]};
        end else if (cp < 32'h800) begin
            run_q = {run_q, 8'hC0 | cp[10:6]};
            run_q = {run_q, 8'h80 | cp[5:0]};
        end else if (cp < 32'h10000) begin
            run_q = {run_q, 8'hE0 | cp[15:12]};
            run_q = {run_q, 8'h80 | cp[11:6]};
            run_q = {run_q, 8'h80 | cp[5:0]};
        end else begin
            run_q = {run_q, 8'hF0 | cp[20:18]};
            run_q = {run_q, 8'h80 | cp[17:12]};
            run_q = {run_q, 8'h80 | cp[11:6]};
            run_q = {run_q, 8'h80 | cp[5:0]};
        end
    endfunction

    // Named entity lookup, own table
    function automatic bit resolve_named();
        string s;
        // a zero byte would vanish from the string, and no name holds one
        foreach (body_q[k]) if (body_q[k] == 8'h00) return 0;
        s = body_str();
        case (s)
            "amp":    put_cp(32'h26);
            "lt":     put_cp(32'h3C);
            "gt":     put_cp(32'h3E);
            "quot":   put_cp(32'h22);
            "apos":   put_cp(32'h27);
            "nbsp":   put_cp(32'hA0);
            "middot": put_cp(32'hB7);
            "sect":   put_cp(32'hA7);
            "para":   put_cp(32'hB6);
            "laquo":  put_cp(32'hAB);
            "raquo":  put_cp(32'hBB);
            "copy":   put_cp(32'hA9);
            "reg":    put_cp(32'hAE);
            "deg":    put_cp(32'hB0);
            "plusmn": put_cp(32'hB1);
            "times":  put_cp(32'hD7);
            "divide": put_cp(32'hF7);
            "ndash":  put_cp(32'h2013);
            "mdash":  put_cp(32'h2014);
            "lsquo":  put_cp(32'h2018);
            "rsquo":  put_cp(32'h2019);
            "ldquo":  put_cp(32'h201C);
            "rdquo":  put_cp(32'h201D);
            "bull":   put_cp(32'h2022);
            "hellip": put_cp(32'h2026);
            "euro":   put_cp(32'h20AC);
            "trade":  put_cp(32'h2122);
            "larr":   put_cp(32'h2190);
            "uarr":   put_cp(32'h2191);
            "rarr":   put_cp(32'h2192);
            "darr":   put_cp(32'h2193);
            "harr":   put_cp(32'h2194);
            default:  return 0;
        endcase
        return 1;
    endfunction

    function automatic bit resolve_numeric();
        int unsigned pos, cp, d;
        bit hex;
        logic [7:0] c;
        if (body_q.size() < 2 || body_q[0] != hed_pkg::ChHash) return 0;
        hex = (body_q[1] == hed_pkg::ChXLo || body_q[1] == hed_pkg::ChXUp);
        pos = hex ? 2 : 1;
        if (pos >= body_q.size()) return 0;
        cp = 0;
        for (; pos < body_q.size(); pos++) begin
            c = body_q[pos];
            if (c >= "0" && c <= "9") d = c - "0";
            else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
            else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
            else return 0;
            cp = cp * (hex ? 16 : 10) + d;
            if (cp > 32'h10FFFF) cp = 32'h110000;
        end
        put_cp(cp);
        return 1;
    endfunction

    function automatic void flush_body();
        run_q = {run_q, hed_pkg::ChAmp};
        foreach (body_q[k]) run_q = {run_q, body_q[k]};
    endfunction

    // Predict the output run of one accepted request
    function automatic void decode_request(input logic [7:0] b, input logic eot);
        logic [7:0] tmp[$];
        int k;
        t_decoded r;
        run_q.delete();
        if (!open_ent) begin
            if (b == hed_pkg::ChAmp) begin
                open_ent = 1;
                body_q.delete();
            end else begin
                run_q = {run_q, b};
            end
        end else if (b == hed_pkg::ChSemi) begin
            if (!resolve_named() && !resolve_numeric()) begin
                flush_body();
                run_q = {run_q, hed_pkg::ChSemi};
            end
            open_ent = 0;
            body_q.delete();
        end else if (body_q.size() < hed_pkg::MaxBody) begin
            body_q = {body_q, b};
        end else begin
            // overflow: emit up to first held '&', keep the rest
            tmp = body_q;
            tmp = {tmp, b};
            run_q = {run_q, hed_pkg::ChAmp};
            for (k = 0; k < tmp.size() && tmp[k] != hed_pkg::ChAmp; k++)
                run_q = {run_q, tmp[k]};
            body_q.delete();
            if (k < tmp.size()) begin
                for (int j = k + 1; j < tmp.size(); j++) body_q = {body_q, tmp[j]};
            end else begin
                open_ent = 0;
            end
        end
        if (eot) begin
            if (open_ent) flush_body();
            open_ent = 0;
            body_q.delete();
        end
        foreach (run_q[j]) begin
            r.b = run_q[j];
            r.last = (j == run_q.size() - 1);
            r.done = r.last && eot;
            decoded_q = {decoded_q, r};
        end
    endfunction

    // Watch both channels
    always @(posedge i_clk) begin
        t_decoded e;
        if (!i_rst_n) begin
            open_ent = 0;
            body_q.delete();
            decoded_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid && !i_stall_in) decode_request(i_text_byte, i_end_of_text);
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected output byte %h", i_out_byte);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = decoded_q.pop_front();
                    if (e.b !== i_out_byte || e.last !== i_last_of_run
                            || e.done !== i_text_done) begin
                        o_fail_count <= o_fail_count + 1;
                        if (e.b !== i_out_byte)
                            $error("out_byte expected %h got %h", e.b, i_out_byte);
                        if (e.last !== i_last_of_run)
                            $error("last_of_run expected %b got %b", e.last, i_last_of_run);
                        if (e.done !== i_text_done)
                            $error("text_done expected %b got %b", e.done, i_text_done);
                    end
                end
            end
        end
        o_pending <= decoded_q.size();
    end
endmodule

// ----- test/html_entity_decoder_top_tb.sv -----
module html_entity_decoder_top_tb;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_text_byte;
    logic       i_end_of_text;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_text_done;
    int         fail_count;
    int         pending;
    bit         long_hold;

    html_entity_decoder_top u_top (.*);

    html_entity_decoder_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_text_byte(i_text_byte), .i_end_of_text(i_end_of_text),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_byte(o_out_byte), .i_last_of_run(o_last_of_run),
        .i_text_done(o_text_done),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall pattern, with one long hold-off
    initial begin
        int mode;
        i_stall = 0;
        @(negedge i_clk);
        while (1) begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1;
                repeat (300) @(negedge i_clk);
                long_hold = 0;
                i_stall <= 0;
            end else begin
                mode = ($urandom_range(0, 7) == 0) ? 0 : 1;
                i_stall <= mode ? ($urandom_range(0, 3) == 0) : 1'b0;
            end
        end
    end

    int burst_left;

    // Offer one request, respecting bursts
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid       <= 1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s, input logic eot);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], eot && k == s.len() - 1);
    endtask

    function automatic string rand_word();
        string names[] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "middot",
            "sect", "para", "laquo", "raquo", "copy", "reg", "deg", "plusmn",
            "times", "divide", "ndash", "mdash", "lsquo", "rsquo", "ldquo",
            "rdquo", "bull", "hellip", "euro", "trade", "larr", "uarr", "rarr",
            "darr", "harr", "Amp", "ampx", "#", "#x", "#0", "#xD800", "#1114112",
            "#x10FFFF", "#xFFFFFFFF", "#65", "#x7ff", "#X1F600", "#12a", "#xg"};
        string s;
        int n;
        case ($urandom_range(0, 5))
            0, 1: s = names[$urandom_range(0, names.size() - 1)];
            2: s = $sformatf("#%0d", $urandom_range(0, 1200000));
            3: s = $sformatf("#x%0h", $urandom_range(0, 32'h120000));
            default: begin
                s = "";
                n = $urandom_range(0, 40);
                for (int k = 0; k < n; k++) begin
                    byte c;
                    c = ($urandom_range(0, 9) == 0) ? "&" : $urandom_range(0, 255);
                    if (c == ";") c = "a";
                    s = {s, string'(c)};
                end
            end
        endcase
        return s;
    endfunction

    initial begin
        int count;
        string w;
        bit hold_started;
        i_rst_n = 0;
        i_valid = 0;
        i_text_byte = 0;
        i_end_of_text = 0;
        long_hold = 0;
        hold_started = 0;
        burst_left = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes, named, numeric, invalid, empty, overflow, flushes
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_str("&amp;&harr;&;&#0;&#xD800;", 0);
        send_str("&#X10FFFF;&#1114112;&Bad;", 0);
        send_str("&abcdefghijklmnopqrstuvwxyz0123456", 0);
        send_str("&abcdefghij&klmnopqrstuvwxyz01234567;", 0);
        send_str("&pend", 1);
        send_byte(8'h41, 1);

        // Random text; long hold-off partway through
        count = 0;
        while (count < 500) begin
            if (count > 150 && !hold_started) begin
                long_hold = 1;
                hold_started = 1;
            end
            if ($urandom_range(0, 2) == 0) begin
                w = {"&", rand_word()};
                if ($urandom_range(0, 5) != 0) w = {w, ";"};
            end else begin
                w = string'(byte'($urandom_range(0, 255)));
            end
            send_str(w, $urandom_range(0, 15) == 0);
            count += w.len();
        end
        send_byte(8'h2E, 1);
        i_valid <= 0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end
endmodule

// ----- html_entity_decoder_top.f -----
+incdir+sv
sv/hed_pkg.sv
sv/hed_front.sv
sv/hed_back.sv
sv/html_entity_decoder_top.sv
test/html_entity_decoder_checker.sv
test/html_entity_decoder_top_tb.sv
